@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/fbfm_pkg.sv @@
package fbfm_pkg;

    // Depth of the displacement store; kept_count is sized to hold it.
    localparam int STORE_DEPTH = 256;
    localparam int COORD_W    = 14;
    localparam int DISP_W     = 15;
    localparam int TOL_W      = 8;
    localparam int SQ_W       = 28;
    localparam int ERR_W      = SQ_W + 1;
    localparam int TOL_SQ_W   = 2 * TOL_W;
    localparam int KEPT_W     = 9;
    localparam int BIT_IDX_W  = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [TOL_W-1:0]     TOL_RESET   = 8'd16;
    // Flip the sign bit so signed displacements order as unsigned keys.
    localparam logic [DISP_W-1:0]    SIGN_FLIP   = 15'h4000;
    localparam logic [BIT_IDX_W-1:0] TOP_BIT     = 4'd14;
    // Register index taken from the word address.
    localparam logic                 REG_TOL_IDX = 1'b0;

    typedef struct packed {
        logic              en;
        logic [DISP_W-1:0] u;
        logic [DISP_W-1:0] v;
    } fbfm_wr_t;

    typedef struct packed {
        logic              done;
        logic [DISP_W-1:0] med_u;
        logic [DISP_W-1:0] med_v;
    } fbfm_res_t;

endpackage

@@ rtl/forward_backward_flow_median.sv @@
// Each feature passes through capture, square, and check and store; a new word is taken only after the last is checked.
// Frame end: the median search runs 15 bit passes over the n stored entries in the
// displacement memories, then finishes and loads the output register.
// A frame with nothing kept skips the median search and goes straight to the output.
// Reset (rst_n low, async) clears the control state and the kept count, and sets the
// tolerance to 16; the displacement memories are not cleared.
module forward_backward_flow_median
    import fbfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // prev_x, prev_y, cur_x, cur_y, back_x, back_y, 4 zero bits
    input  logic [87:0]           s_axis_tdata,
    // forward_ok, backward_ok
    input  logic [1:0]            s_axis_tuser,
    // last_feature
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // kept_count, median_u, median_v, 1 zero bit
    output logic [39:0]           m_axis_tdata,
    // has_median
    output logic [0:0]            m_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQ   = 5'b00010,
        S_CHK  = 5'b00100,
        S_MED  = 5'b01000,
        S_OUT  = 5'b10000
    } fbfm_state_t;

    fbfm_state_t         state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [TOL_W-1:0]    tol_reg;
    logic                m_valid_reg, m_valid_next;

    logic [COORD_W-1:0]  px_reg, py_reg, cx_reg, cy_reg, bx_reg, by_reg;
    logic                fwd_reg, bwd_reg, last_reg;
    logic [SQ_W-1:0]     sqx_reg, sqy_reg;
    logic [TOL_SQ_W-1:0] tol_sq_reg;
    logic [DISP_W-1:0]   u_reg, v_reg;
    logic [KEPT_W-1:0]   kept_reg;
    logic [DISP_W-1:0]   med_u_reg, med_v_reg;
    logic                has_reg;

    logic                s_accept, cfg_write, out_load;
    logic signed [DISP_W-1:0]     ex, ey;
    logic signed [2*DISP_W-1:0]   prod_x, prod_y;
    logic [TOL_SQ_W-1:0] tol_sq;
    logic [ERR_W-1:0]    err2;
    logic                keep, start;
    fbfm_wr_t            wr;
    fbfm_res_t           res;

    assign pready        = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_write     = psel && penable && pwrite && pready && (paddr[2] == REG_TOL_IDX);
    assign prdata        = (paddr[2] == REG_TOL_IDX) ? APB_DATA_W'(tol_reg) : '0;

    assign ex     = DISP_W'({1'b0, bx_reg}) - DISP_W'({1'b0, px_reg});
    assign ey     = DISP_W'({1'b0, by_reg}) - DISP_W'({1'b0, py_reg});
    assign prod_x = (2*DISP_W)'(ex) * (2*DISP_W)'(ex);
    assign prod_y = (2*DISP_W)'(ey) * (2*DISP_W)'(ey);
    assign tol_sq = TOL_SQ_W'(tol_reg) * TOL_SQ_W'(tol_reg);

    assign err2 = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign keep = (state_reg == S_CHK) && fwd_reg && bwd_reg
                  && (err2 <= ERR_W'(tol_sq_reg)) && (count_reg < CW'(STORE_DEPTH));

    assign wr.en   = keep;
    assign wr.u    = u_reg;
    assign wr.v    = v_reg;
    assign start   = (state_reg == S_CHK) && last_reg && (count_next != '0);
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                count_next = count_reg + CW'(keep);
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (count_next != '0)
                begin
                    state_next = S_MED;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_MED:
            begin
                if (res.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Hold until the output register is free, then start a new frame.
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    count_next   = '0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            tol_reg     <= TOL_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write)
            begin
                tol_reg <= pwdata[TOL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            px_reg   <= s_axis_tdata[13:0];
            py_reg   <= s_axis_tdata[27:14];
            cx_reg   <= s_axis_tdata[41:28];
            cy_reg   <= s_axis_tdata[55:42];
            bx_reg   <= s_axis_tdata[69:56];
            by_reg   <= s_axis_tdata[83:70];
            fwd_reg  <= s_axis_tuser[0];
            bwd_reg  <= s_axis_tuser[1];
            last_reg <= s_axis_tlast;
        end
        if (state_reg == S_SQ)
        begin
            sqx_reg    <= prod_x[SQ_W-1:0];
            sqy_reg    <= prod_y[SQ_W-1:0];
            tol_sq_reg <= tol_sq;
            u_reg      <= DISP_W'({1'b0, cx_reg}) - DISP_W'({1'b0, px_reg});
            v_reg      <= DISP_W'({1'b0, cy_reg}) - DISP_W'({1'b0, py_reg});
        end
        if (out_load)
        begin
            kept_reg  <= KEPT_W'(count_reg);
            has_reg   <= (count_reg != '0);
            med_u_reg <= (count_reg != '0) ? res.med_u : '0;
            med_v_reg <= (count_reg != '0) ? res.med_v : '0;
        end
    end

    fbfm_median u_median (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .wr_addr(count_reg[AW-1:0]),
        .start  (start),
        .count  (count_next),
        .res    (res)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, med_v_reg, med_u_reg, kept_reg};
    assign m_axis_tuser  = has_reg;

endmodule

@@ rtl/fbfm_median.sv @@
module fbfm_median
    import fbfm_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  fbfm_wr_t                           wr,
    input  logic [$clog2(STORE_DEPTH)-1:0]     wr_addr,
    input  logic                               start,
    input  logic [$clog2(STORE_DEPTH+1)-1:0]   count,
    output fbfm_res_t                          res
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    typedef enum logic [1:0] {
        M_IDLE = 2'b01,
        M_SCAN = 2'b10
    } med_state_t;

    med_state_t         state_reg, state_next;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      rd_addr_reg, rd_addr_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [CW-1:0]      cnt_u_reg, cnt_u_next;
    logic [CW-1:0]      cnt_v_reg, cnt_v_next;
    logic [CW-1:0]      rank_u_reg, rank_u_next;
    logic [CW-1:0]      rank_v_reg, rank_v_next;
    logic [DISP_W-1:0]  prefix_u_reg, prefix_u_next;
    logic [DISP_W-1:0]  prefix_v_reg, prefix_v_next;
    logic [DISP_W-1:0]  mask_reg, mask_next;
    logic [BIT_IDX_W-1:0] bit_reg, bit_next;
    logic               done_reg, done_next;

    logic [DISP_W-1:0]  u_mem [STORE_DEPTH];
    logic [DISP_W-1:0]  v_mem [STORE_DEPTH];
    logic [DISP_W-1:0]  rd_u_reg, rd_v_reg;

    logic               issue, pass_done;
    logic [DISP_W-1:0]  key_u, key_v, one_hot;
    logic               hit_u, hit_v;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            u_mem[wr_addr] <= wr.u;
            v_mem[wr_addr] <= wr.v;
        end
        rd_u_reg <= u_mem[rd_addr_reg[AW-1:0]];
        rd_v_reg <= v_mem[rd_addr_reg[AW-1:0]];
    end

    assign issue     = (state_reg == M_SCAN) && (rd_addr_reg < n_reg);
    assign pass_done = (state_reg == M_SCAN) && (rd_addr_reg == n_reg) && !rd_vld_reg;

    assign key_u   = rd_u_reg ^ SIGN_FLIP;
    assign key_v   = rd_v_reg ^ SIGN_FLIP;
    // Count entries that share the decided upper bits and hold a zero here.
    assign hit_u   = (((key_u ^ prefix_u_reg) & mask_reg) == '0) && !key_u[bit_reg];
    assign hit_v   = (((key_v ^ prefix_v_reg) & mask_reg) == '0) && !key_v[bit_reg];
    assign one_hot = DISP_W'(1) << bit_reg;

    always_comb
    begin
        state_next    = state_reg;
        rd_addr_next  = rd_addr_reg;
        rd_vld_next   = issue;
        cnt_u_next    = cnt_u_reg;
        cnt_v_next    = cnt_v_reg;
        rank_u_next   = rank_u_reg;
        rank_v_next   = rank_v_reg;
        prefix_u_next = prefix_u_reg;
        prefix_v_next = prefix_v_reg;
        mask_next     = mask_reg;
        bit_next      = bit_reg;
        done_next     = 1'b0;

        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next    = M_SCAN;
                    rd_addr_next  = '0;
                    cnt_u_next    = '0;
                    cnt_v_next    = '0;
                    rank_u_next   = count >> 1;
                    rank_v_next   = count >> 1;
                    prefix_u_next = '0;
                    prefix_v_next = '0;
                    mask_next     = '0;
                    bit_next      = TOP_BIT;
                end
            end
            M_SCAN:
            begin
                if (issue)
                begin
                    rd_addr_next = rd_addr_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    cnt_u_next = cnt_u_reg + CW'(hit_u);
                    cnt_v_next = cnt_v_reg + CW'(hit_v);
                end
                if (pass_done)
                begin
                    // Rank falls past the zero group: take a one and skip that group.
                    if (rank_u_reg >= cnt_u_reg)
                    begin
                        prefix_u_next = prefix_u_reg | one_hot;
                        rank_u_next   = rank_u_reg - cnt_u_reg;
                    end
                    if (rank_v_reg >= cnt_v_reg)
                    begin
                        prefix_v_next = prefix_v_reg | one_hot;
                        rank_v_next   = rank_v_reg - cnt_v_reg;
                    end
                    cnt_u_next   = '0;
                    cnt_v_next   = '0;
                    rd_addr_next = '0;
                    mask_next    = {1'b1, mask_reg[DISP_W-1:1]};
                    bit_next     = bit_reg - BIT_IDX_W'(1);
                    if (bit_reg == '0)
                    begin
                        state_next = M_IDLE;
                        done_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= M_IDLE;
            rd_addr_reg <= '0;
            rd_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_addr_reg <= rd_addr_next;
            rd_vld_reg  <= rd_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == M_IDLE))
        begin
            n_reg <= count;
        end
        cnt_u_reg    <= cnt_u_next;
        cnt_v_reg    <= cnt_v_next;
        rank_u_reg   <= rank_u_next;
        rank_v_reg   <= rank_v_next;
        prefix_u_reg <= prefix_u_next;
        prefix_v_reg <= prefix_v_next;
        mask_reg     <= mask_next;
        bit_reg      <= bit_next;
    end

    assign res.done  = done_reg;
    assign res.med_u = prefix_u_reg ^ SIGN_FLIP;
    assign res.med_v = prefix_v_reg ^ SIGN_FLIP;

endmodule

@@ rtl/fbfm_checker.sv @@
`include "assert_macros.svh"

module fbfm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    logic        out_stall;
    logic [40:0] out_word;
    logic        has_count;
    logic        med_zero;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tuser, m_axis_tdata};
    assign has_count = (m_axis_tdata[8:0] != 9'd0);
    assign med_zero  = (m_axis_tdata[38:9] == 30'd0);

    // A stalled result word holds its value.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_word))

    // Each feature word is worked on alone: no acceptance right after one.
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // has_median follows the kept count.
    `ASSERT_IMPLY(a_has_matches_count, clk, rst_n, m_axis_tvalid, m_axis_tuser[0] == has_count)

    // An empty frame reports zero medians.
    `ASSERT_IMPLY(a_empty_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], med_zero)

endmodule

bind forward_backward_flow_median fbfm_checker u_fbfm_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import fbfm_pkg::*;

    localparam int MAX_KEPT    = STORE_DEPTH;
    localparam int COORD_MAX   = 16383;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = 20;
    localparam int FRAME_ITEMS = 140;
    localparam int BIG_FRAME   = 265;
    localparam logic [APB_ADDR_W-1:0] TOL_ADDR = {REG_TOL_IDX, 2'b00};

    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic               fwd;
        logic               bwd;
        logic               last;
    } feature_t;

    typedef struct packed {
        logic [KEPT_W-1:0] count;
        logic [DISP_W-1:0] mu;
        logic [DISP_W-1:0] mv;
        logic              has;
    } flow_result_t;

    typedef struct packed {
        feature_t     f;
        logic         typed;
        flow_result_t want;
    } vector_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // prev_x, prev_y, cur_x, cur_y, back_x, back_y, 4 zero bits
    logic [87:0]           s_axis_tdata;
    // forward_ok, backward_ok
    logic [1:0]            s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // kept_count, median_u, median_v, 1 zero bit
    logic [39:0]           m_axis_tdata;
    // has_median
    logic [0:0]            m_axis_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    forward_backward_flow_median u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow of the block: kept displacements, kept count, tolerance.
    logic signed [DISP_W-1:0] kept_u [0:MAX_KEPT-1];
    logic signed [DISP_W-1:0] kept_v [0:MAX_KEPT-1];
    int                       kept_n;
    logic [TOL_W-1:0]         tol_shadow;

    flow_result_t pending_medians [$];
    vector_row_t  vectors [$];
    int           fail_count;
    int           idle_pct;
    int           stall_pct;
    int           holds_asked;
    int           holds_done;
    int           hold_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int clip_coord(input int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic logic signed [DISP_W-1:0] upper_median(input bit use_v);
        logic signed [DISP_W-1:0] vals [0:MAX_KEPT-1];
        logic signed [DISP_W-1:0] key;
        int i;
        int j;
        for (i = 0; i < kept_n; i++)
            vals[i] = use_v ? kept_v[i] : kept_u[i];
        for (i = 1; i < kept_n; i++)
        begin
            key = vals[i];
            j = i - 1;
            while (j >= 0 && vals[j] > key)
            begin
                vals[j + 1] = vals[j];
                j--;
            end
            vals[j + 1] = key;
        end
        return vals[kept_n / 2];
    endfunction

    // Judge one accepted feature; on a frame end, return the result and clear the frame.
    function automatic bit judge_feature(input feature_t f, output flow_result_t res);
        longint ex;
        longint ey;
        ex = longint'(f.bx) - longint'(f.px);
        ey = longint'(f.by) - longint'(f.py);
        res = '0;
        if (f.fwd && f.bwd
            && (ex * ex + ey * ey <= longint'(tol_shadow) * longint'(tol_shadow))
            && kept_n < MAX_KEPT)
        begin
            kept_u[kept_n] = DISP_W'(int'(f.cx) - int'(f.px));
            kept_v[kept_n] = DISP_W'(int'(f.cy) - int'(f.py));
            kept_n++;
        end
        if (!f.last)
            return 1'b0;
        res.count = KEPT_W'(kept_n);
        res.has   = (kept_n != 0);
        if (kept_n != 0)
        begin
            res.mu = upper_median(1'b0);
            res.mv = upper_median(1'b1);
        end
        kept_n = 0;
        return 1'b1;
    endfunction

    function automatic feature_t make_feature(input bit last);
        feature_t f;
        int t;
        int r;
        t = int'(tol_shadow);
        f.px = COORD_W'($urandom_range(0, COORD_MAX));
        f.py = COORD_W'($urandom_range(0, COORD_MAX));
        if ($urandom_range(9) < 2)
        begin
            f.cx = COORD_W'($urandom_range(0, COORD_MAX));
            f.cy = COORD_W'($urandom_range(0, COORD_MAX));
        end
        else
        begin
            f.cx = COORD_W'(clip_coord(int'(f.px) + int'($urandom_range(0, 80)) - 40));
            f.cy = COORD_W'(clip_coord(int'(f.py) + int'($urandom_range(0, 80)) - 40));
        end
        r = $urandom_range(99);
        if (r < 10)
        begin
            f.bx = COORD_W'($urandom_range(0, COORD_MAX));
            f.by = COORD_W'($urandom_range(0, COORD_MAX));
        end
        else if (r < 25)
        begin
            // land exactly on the tolerance circle along one axis
            f.bx = COORD_W'(clip_coord(int'(f.px) + ($urandom_range(1) ? t : -t)));
            f.by = f.py;
        end
        else
        begin
            f.bx = COORD_W'(clip_coord(int'(f.px) + int'($urandom_range(0, 2 * t + 4))
                                       - (t + 2)));
            f.by = COORD_W'(clip_coord(int'(f.py) + int'($urandom_range(0, 2 * t + 4))
                                       - (t + 2)));
        end
        f.fwd  = ($urandom_range(99) < 90);
        f.bwd  = ($urandom_range(99) < 90);
        f.last = last;
        return f;
    endfunction

    function automatic void add_row(input int px, input int py, input int cx, input int cy,
                                    input int bx, input int by, input bit fwd, input bit bwd,
                                    input bit last, input bit typed, input int count,
                                    input int mu, input int mv, input bit has);
        vector_row_t row;
        row.f.px       = COORD_W'(px);
        row.f.py       = COORD_W'(py);
        row.f.cx       = COORD_W'(cx);
        row.f.cy       = COORD_W'(cy);
        row.f.bx       = COORD_W'(bx);
        row.f.by       = COORD_W'(by);
        row.f.fwd      = fwd;
        row.f.bwd      = bwd;
        row.f.last     = last;
        row.typed      = typed;
        row.want.count = KEPT_W'(count);
        row.want.mu    = DISP_W'(mu);
        row.want.mv    = DISP_W'(mv);
        row.want.has   = has;
        vectors = {vectors, row};
    endfunction

    task automatic send_feature(input feature_t f, input bit typed, input flow_result_t want);
        flow_result_t res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, f.by, f.bx, f.cy, f.cx, f.py, f.px};
        s_axis_tuser  <= {f.bwd, f.fwd};
        s_axis_tlast  <= f.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (judge_feature(f, res))
            pending_medians = {pending_medians, (typed ? want : res)};
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic apb_xfer(input bit wr, input logic [APB_DATA_W-1:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TOL_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (pready !== 1'b1)
        begin
            $display("%0t pready: expected 1, actual %0b", $time, pready);
            fail_count++;
        end
        if (wr)
            tol_shadow = wdata[TOL_W-1:0];
        else if (prdata !== APB_DATA_W'(tol_shadow))
        begin
            $display("%0t tolerance readback: expected %0d, actual %0d",
                     $time, tol_shadow, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Receiver: random backpressure, plus a long hold-off when one is asked for.
    initial
    begin
        m_axis_tready <= 1'b0;
        hold_left = 0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                hold_left = HOLD_CYCLES;
                holds_done = holds_asked;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        flow_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_medians.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual 0x%0h / %0b",
                         $time, m_axis_tdata, m_axis_tuser);
                fail_count++;
            end
            else
            begin
                want = pending_medians.pop_front();
                check_field("kept_count", want.count, m_axis_tdata[8:0]);
                check_field("median_u", want.mu, m_axis_tdata[23:9]);
                check_field("median_v", want.mv, m_axis_tdata[38:24]);
                check_field("has_median", want.has, m_axis_tuser[0]);
            end
        end
    end

    initial
    begin
        feature_t     f;
        vector_row_t  row;
        int           phase;
        int           sent;
        int           len;
        int           k;
        logic [TOL_W-1:0] tol;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        fail_count  = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        holds_asked = 0;
        kept_n      = 0;
        tol_shadow  = TOL_RESET;

        //      px     py     cx     cy     bx     by    fw bw ls ty cnt  mu      mv   has
        add_row(0,     0,     0,     0,     0,     0,     0, 0, 1, 1, 0,  0,      0,      0);
        add_row(0,     16383, 16383, 0,     0,     16383, 1, 1, 1, 1, 1,  16383,  -16383, 1);
        add_row(0,     16383, 16383, 0,     0,     16383, 1, 0, 1, 1, 0,  0,      0,      0);
        add_row(0,     16383, 16383, 0,     0,     16383, 0, 1, 1, 1, 0,  0,      0,      0);
        // error exactly at the tolerance is kept, one step beyond is dropped
        add_row(1000,  2000,  1000,  2000,  1016,  2000,  1, 1, 1, 1, 1,  0,      0,      1);
        add_row(1000,  2000,  1000,  2000,  1016,  2001,  1, 1, 1, 1, 0,  0,      0,      0);
        add_row(16383, 16383, 16383, 16383, 16383, 16383, 1, 1, 0, 0, 0,  0,      0,      0);
        add_row(100,   100,   105,   97,    100,   100,   1, 1, 0, 0, 0,  0,      0,      0);
        add_row(100,   100,   97,    110,   100,   100,   1, 1, 0, 0, 0,  0,      0,      0);
        add_row(100,   100,   110,   107,   100,   100,   0, 1, 0, 0, 0,  0,      0,      0);
        add_row(100,   100,   107,   105,   100,   100,   1, 1, 1, 0, 0,  0,      0,      0);
        // even count with ties: the upper middle is taken
        add_row(300,   300,   302,   292,   300,   300,   1, 1, 0, 0, 0,  0,      0,      0);
        add_row(300,   300,   302,   292,   300,   300,   1, 1, 0, 0, 0,  0,      0,      0);
        add_row(300,   300,   299,   304,   300,   300,   1, 1, 0, 0, 0,  0,      0,      0);
        add_row(300,   300,   309,   304,   300,   300,   1, 1, 1, 0, 0,  0,      0,      0);
        add_row(500,   500,   520,   500,   484,   500,   1, 1, 1, 1, 1,  20,     0,      1);
        add_row(500,   500,   520,   500,   488,   488,   1, 1, 1, 1, 0,  0,      0,      0);
        add_row(0,     0,     0,     0,     16383, 16383, 1, 1, 1, 1, 0,  0,      0,      0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tolerance after reset
        apb_xfer(1'b0, '0);
        foreach (vectors[i])
        begin
            row = vectors[i];
            send_feature(row.f, row.typed, row.want);
        end

        for (phase = 0; phase < 8; phase++)
        begin
            wait_drained();
            case (phase)
                0, 6:    tol = '0;
                1, 5:    tol = '1;
                2:       tol = TOL_RESET;
                default: tol = TOL_W'($urandom_range(1, 254));
            endcase
            apb_xfer(1'b1, APB_DATA_W'(tol));
            apb_xfer(1'b0, '0);
            case (phase % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 88;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 88;
                end
                default:
                begin
                    idle_pct  = 14;
                    stall_pct = 14;
                end
            endcase
            sent = 0;
            if (phase == 0)
            begin
                // hold the output side while one-word frames keep arriving
                holds_asked++;
                repeat (40) send_feature(make_feature(1'b1), 1'b0, '0);
                sent += 40;
            end
            if (phase == 2 || phase == 7)
            begin
                // overfill the store so the count saturates
                for (k = 0; k < BIG_FRAME; k++)
                begin
                    f = make_feature(k == BIG_FRAME - 1);
                    f.fwd = 1'b1;
                    f.bwd = 1'b1;
                    f.bx  = f.px;
                    f.by  = f.py;
                    send_feature(f, 1'b0, '0);
                end
            end
            while (sent < FRAME_ITEMS)
            begin
                len = $urandom_range(1, 12);
                for (k = 0; k < len; k++)
                    send_feature(make_feature(k == len - 1), 1'b0, '0);
                sent += len;
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
